@@ design/csmh_pkg.sv @@
// Shared types and constants of the cut scan mass histogram.
// Used by the preparation stage, the counter cells and the top level.
package csmh_pkg;

  // Widths of the command fields, sized for the largest parameter values.
  localparam int ROWS_W  = 9;   // 0..256 cut rows filled
  localparam int MADDR_W = 12;  // mass bin address, up to 4096 stored bins
  localparam int SADDR_W = 9;   // score bin address, up to 258 stored bins
  localparam int COUNT_W = 32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENT_MIN  = 3'd0;
  localparam logic [2:0] CFG_CENT_MAX  = 3'd1;
  localparam logic [2:0] CFG_PT_MIN    = 3'd2;
  localparam logic [2:0] CFG_PT_MAX    = 3'd3;
  localparam logic [2:0] CFG_ORIGIN    = 3'd4;
  localparam logic [2:0] CFG_BIN_COUNT = 3'd5;

  // Input item kinds.
  localparam logic KIND_CANDIDATE = 1'b0;
  localparam logic KIND_READ      = 1'b1;

  // Read table selectors.
  localparam logic TABLE_MASS  = 1'b0;
  localparam logic TABLE_SCORE = 1'b1;

  // Score scale: scores run over -SCORE_HALF..SCORE_HALF.
  localparam logic signed [15:0] SCORE_HALF = 16'sd10000;
  localparam logic signed [15:0] SCORE_SPAN = 16'sd20000;
  localparam int unsigned SCORE_SPAN_U = 20000;

  // Division by 500 keV bin width: floor(x * MASS_RECIP / 2^MASS_SHIFT).
  localparam logic [22:0] MASS_RECIP = 23'd4294968;
  localparam int MASS_SHIFT = 31;

  // Ceiling of score offset over the 100-unit cut step.
  localparam logic [15:0] ROWS_ROUND = 16'd99;
  localparam logic [15:0] ROWS_RECIP = 16'd41944;
  localparam int ROWS_SHIFT = 22;

  // Score bin scale shift; the factor itself follows from SCORE_BINS.
  localparam int SCORE_SHIFT = 29;

  // Configuration register file contents.
  typedef struct packed {
    logic [7:0]  cent_min;
    logic [7:0]  cent_max;
    logic [15:0] pt_min;
    logic [15:0] pt_max;
    logic [20:0] origin;
    logic [8:0]  bin_count;
  } cfg_t;

  // Clearing pass control, broadcast to every counter cell.
  typedef struct packed {
    logic               active;
    logic [MADDR_W-1:0] addr;
  } clr_t;

  // One transaction as it travels down the cell chain.
  typedef struct packed {
    logic               valid;
    logic               accepted;
    logic [ROWS_W-1:0]  rows;
    logic [MADDR_W-1:0] mass_addr;
    logic               mass_rd_ok;
    logic [SADDR_W-1:0] score_addr;
    logic               score_rd_ok;
    logic [7:0]         read_row;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

@@ design/cut_scan_mass_histogram_top.sv @@
// Top level of the cut scan mass histogram: ports, configuration, clearing
// pass, output register. Depends on csmh_pkg, csmh_prep and csmh_cell.
//
//   channel | direction | handshake        | payload
//   in_     | slave     | tvalid / tready  | tdata 80 bit, tuser 2 bit
//   out_    | master    | tvalid / tready  | tdata 40 bit, tuser 1 bit
//   cfg_    | write     | wr_en            | index 3 bit, data 21 bit
//
// One transaction enters per cycle while the chain is not stalled or clearing; its
// result passes the preparation registers, the score cell, one counter cell per
// cut row behind it and the output register. After reset a clearing pass zeroes
// every address of every counter memory; in_tready stays low meanwhile.
// A stalled output register freezes the whole chain and holds in_tready low.
module cut_scan_mass_histogram_top #(
  parameter int CUT_ROWS      = 200,
  parameter int MAX_MASS_BINS = 510,
  parameter int SCORE_BINS    = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mass_kev[20:0], score[35:21], centrality[43:36], momentum_mev[59:44],
  // read_row[67:60], read_bin[76:68], zero pad[79:77]
  input  logic [79:0] in_tdata,
  // kind[0], read_table[1]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // rows_filled[7:0], count[39:8]
  output logic [39:0] out_tdata,
  // accepted[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int MASS_STRIDE = MAX_MASS_BINS + 2;
  localparam int SCORE_DEPTH = SCORE_BINS + 2;
  localparam int CLR_DEPTH   = (MASS_STRIDE > SCORE_DEPTH) ? MASS_STRIDE : SCORE_DEPTH;
  localparam logic [csmh_pkg::MADDR_W-1:0] CLR_LAST = csmh_pkg::MADDR_W'(CLR_DEPTH - 1);

  csmh_pkg::cfg_t cfg_r;
  csmh_pkg::clr_t clr_r;
  csmh_pkg::cmd_t prep_cmd;
  csmh_pkg::cmd_t chain [CUT_ROWS + 1];

  logic        en;
  logic        in_fire;
  logic        out_valid_r;
  logic        out_acc_r;
  logic [7:0]  out_rows_r;
  logic [31:0] out_count_r;

  // The chain advances whenever the output register can take a result.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && !clr_r.active;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cent_min  <= 8'd0;
      cfg_r.cent_max  <= 8'd200;
      cfg_r.pt_min    <= 16'd0;
      cfg_r.pt_max    <= 16'd65535;
      cfg_r.origin    <= 21'd1080000;
      cfg_r.bin_count <= 9'd160;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        csmh_pkg::CFG_CENT_MIN:  cfg_r.cent_min  <= cfg_data[7:0];
        csmh_pkg::CFG_CENT_MAX:  cfg_r.cent_max  <= cfg_data[7:0];
        csmh_pkg::CFG_PT_MIN:    cfg_r.pt_min    <= cfg_data[15:0];
        csmh_pkg::CFG_PT_MAX:    cfg_r.pt_max    <= cfg_data[15:0];
        csmh_pkg::CFG_ORIGIN:    cfg_r.origin    <= cfg_data;
        csmh_pkg::CFG_BIN_COUNT: cfg_r.bin_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Clearing pass over all counter memories after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r.active <= 1'b1;
      clr_r.addr   <= '0;
    end else if (clr_r.active) begin
      clr_r.addr <= clr_r.addr + 1'b1;
      if (clr_r.addr == CLR_LAST) begin
        clr_r.active <= 1'b0;
      end
    end
  end

  // Bin and row computation.
  csmh_prep #(
    .CUT_ROWS      (CUT_ROWS),
    .MAX_MASS_BINS (MAX_MASS_BINS),
    .SCORE_BINS    (SCORE_BINS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_fire  (in_fire),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg      (cfg_r),
    .cmd_out  (prep_cmd)
  );

  // Score histogram cell at the head of the chain.
  csmh_cell #(
    .IS_SCORE (1'b1),
    .ROW_IDX  (0),
    .DEPTH    (SCORE_DEPTH)
  ) u_score_cell (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .clr     (clr_r),
    .cmd_in  (prep_cmd),
    .cmd_out (chain[0])
  );

  // One mass histogram cell per cut row.
  for (genvar i = 0; i < CUT_ROWS; i++) begin : g_row
    csmh_cell #(
      .IS_SCORE (1'b0),
      .ROW_IDX  (i),
      .DEPTH    (MASS_STRIDE)
    ) u_row_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .clr     (clr_r),
      .cmd_in  (chain[i]),
      .cmd_out (chain[i + 1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[CUT_ROWS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_acc_r   <= chain[CUT_ROWS].accepted;
      out_rows_r  <= chain[CUT_ROWS].rows[7:0];
      out_count_r <= chain[CUT_ROWS].count;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_count_r, out_rows_r};
  assign out_tuser[0] = out_acc_r;

endmodule

@@ design/csmh_prep.sv @@
// Preparation stages: window cut, mass bin, filled row count and score bin.
// Depends on csmh_pkg; feeds the head of the counter cell chain.
module csmh_prep #(
  parameter int CUT_ROWS      = 200,
  parameter int MAX_MASS_BINS = 510,
  parameter int SCORE_BINS    = 200
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_fire,
  input  logic [79:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  input  csmh_pkg::cfg_t     cfg,
  output csmh_pkg::cmd_t     cmd_out
);

  localparam int MASS_STRIDE = MAX_MASS_BINS + 2;
  localparam int SCORE_DEPTH = SCORE_BINS + 2;
  localparam logic [23:0] SCORE_RECIP = 24'(((64'd1 << csmh_pkg::SCORE_SHIFT)
      * 64'(SCORE_BINS) + 64'(csmh_pkg::SCORE_SPAN_U - 1)) / 64'(csmh_pkg::SCORE_SPAN_U));

  // Unpacked input fields.
  logic               kind;
  logic [20:0]        mass;
  logic [14:0]        score;
  logic [7:0]         cent;
  logic [15:0]        pt;
  logic               read_table;
  logic [7:0]         read_row;
  logic [8:0]         read_bin;

  // First stage arithmetic.
  logic               win_ok;
  logic               under;
  logic [20:0]        offset;
  logic signed [15:0] shifted;
  logic [15:0]        rows_num;
  logic [43:0]        mass_prod;
  logic [30:0]        rows_prod;
  logic [38:0]        score_prod;

  // First stage registers.
  logic               a_valid_r;
  logic               a_kind_r;
  logic               a_pass_r;
  logic               a_under_r;
  logic [12:0]        a_k_r;
  logic [8:0]         a_rows_raw_r;
  logic               a_pos_r;
  logic               a_neg_r;
  logic               a_top_r;
  logic [8:0]         a_sbin_raw_r;
  logic               a_table_r;
  logic [7:0]         a_row_r;
  logic [8:0]         a_bin_r;

  // Second stage.
  logic [11:0]        nbins;
  logic [8:0]         rows_clip;
  csmh_pkg::cmd_t     cmd_nxt;
  csmh_pkg::cmd_t     cmd_r;

  // Field unpacking, window compare and the three reciprocal products.
  always_comb begin
    kind       = in_tuser[0];
    read_table = in_tuser[1];
    mass       = in_tdata[20:0];
    score      = in_tdata[35:21];
    cent       = in_tdata[43:36];
    pt         = in_tdata[59:44];
    read_row   = in_tdata[67:60];
    read_bin   = in_tdata[76:68];

    win_ok = (cent >= cfg.cent_min) && (cent < cfg.cent_max) &&
             (pt >= cfg.pt_min) && (pt <= cfg.pt_max);
    under  = mass < cfg.origin;
    offset = mass - cfg.origin;

    shifted  = $signed({score[14], score}) + csmh_pkg::SCORE_HALF;
    rows_num = unsigned'(shifted) + csmh_pkg::ROWS_ROUND;

    mass_prod  = 44'(offset) * 44'(csmh_pkg::MASS_RECIP);
    rows_prod  = 31'(rows_num[14:0]) * 31'(csmh_pkg::ROWS_RECIP);
    score_prod = 39'(shifted[14:0]) * 39'(SCORE_RECIP);
  end

  // First stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r     <= kind;
      a_pass_r     <= win_ok && (kind == csmh_pkg::KIND_CANDIDATE);
      a_under_r    <= under;
      a_k_r        <= mass_prod[csmh_pkg::MASS_SHIFT +: 13];
      a_rows_raw_r <= rows_prod[csmh_pkg::ROWS_SHIFT +: 9];
      a_pos_r      <= shifted > 16'sd0;
      a_neg_r      <= shifted < 16'sd0;
      a_top_r      <= shifted >= csmh_pkg::SCORE_SPAN;
      a_sbin_raw_r <= score_prod[csmh_pkg::SCORE_SHIFT +: 9];
      a_table_r    <= read_table;
      a_row_r      <= read_row;
      a_bin_r      <= read_bin;
    end
  end

  // Bin selection and read decode.
  always_comb begin
    nbins = 12'(cfg.bin_count);
    if (cfg.bin_count == 9'd0) begin
      nbins = 12'd1;
    end
    if (32'(nbins) > MAX_MASS_BINS) begin
      nbins = 12'(MAX_MASS_BINS);
    end

    rows_clip = a_rows_raw_r;
    if (32'(a_rows_raw_r) > CUT_ROWS) begin
      rows_clip = 9'(CUT_ROWS);
    end

    cmd_nxt          = '0;
    cmd_nxt.valid    = a_valid_r;
    cmd_nxt.accepted = a_pass_r;
    cmd_nxt.read_row = a_row_r;
    cmd_nxt.count    = '0;

    if (a_kind_r == csmh_pkg::KIND_READ) begin
      cmd_nxt.mass_addr   = 12'(a_bin_r);
      cmd_nxt.score_addr  = a_bin_r;
      cmd_nxt.mass_rd_ok  = (a_table_r == csmh_pkg::TABLE_MASS) &&
                            (32'(a_bin_r) < MASS_STRIDE);
      cmd_nxt.score_rd_ok = (a_table_r == csmh_pkg::TABLE_SCORE) &&
                            (32'(a_bin_r) < SCORE_DEPTH);
    end else begin
      // Mass bin: underflow, in-range bin or overflow.
      if (a_under_r) begin
        cmd_nxt.mass_addr = '0;
      end else if (a_k_r >= {1'b0, nbins}) begin
        cmd_nxt.mass_addr = nbins + 12'd1;
      end else begin
        cmd_nxt.mass_addr = 12'(a_k_r + 13'd1);
      end

      // Score bin: below range, above range or scaled bin.
      if (a_neg_r) begin
        cmd_nxt.score_addr = '0;
      end else if (a_top_r) begin
        cmd_nxt.score_addr = 9'(SCORE_BINS + 1);
      end else begin
        cmd_nxt.score_addr = a_sbin_raw_r + 9'd1;
      end

      if (a_pass_r && a_pos_r) begin
        cmd_nxt.rows = rows_clip;
      end
    end
  end

  // Second stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r.valid <= 1'b0;
    end else if (en) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_out = cmd_r;

endmodule

@@ design/csmh_cell.sv @@
// One counter cell of the chain: a counter memory with read-modify-write.
// Depends on csmh_pkg; used for every cut row and for the score histogram.
module csmh_cell #(
  parameter bit IS_SCORE = 1'b0,
  parameter int ROW_IDX  = 0,
  parameter int DEPTH    = 512
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  csmh_pkg::clr_t clr,
  input  csmh_pkg::cmd_t cmd_in,
  output csmh_pkg::cmd_t cmd_out
);

  localparam int AW = $clog2(DEPTH);

  logic [csmh_pkg::COUNT_W-1:0] mem [DEPTH];

  csmh_pkg::cmd_t               cmd_r;
  logic [csmh_pkg::COUNT_W-1:0] rd_r;
  logic                         byp_r;
  logic [csmh_pkg::COUNT_W-1:0] byp_d_r;

  logic [csmh_pkg::MADDR_W-1:0] in_sel;
  logic [csmh_pkg::MADDR_W-1:0] cur_sel;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                cur_addr;
  logic [csmh_pkg::COUNT_W-1:0] cur;
  logic                         inc;
  logic                         hit;
  logic                         we;
  logic [AW-1:0]                wa;
  logic [csmh_pkg::COUNT_W-1:0] wd;

  // Address of the incoming and of the held transaction.
  always_comb begin
    if (IS_SCORE) begin
      in_sel  = csmh_pkg::MADDR_W'(cmd_in.score_addr);
      cur_sel = csmh_pkg::MADDR_W'(cmd_r.score_addr);
    end else begin
      in_sel  = cmd_in.mass_addr;
      cur_sel = cmd_r.mass_addr;
    end
    rd_addr  = in_sel[AW-1:0];
    cur_addr = cur_sel[AW-1:0];
  end

  // Counter value with forwarding from the write of the cycle before.
  assign cur = byp_r ? byp_d_r : rd_r;

  // Increment and read decisions for the held transaction.
  always_comb begin
    if (IS_SCORE) begin
      inc = cmd_r.valid && cmd_r.accepted;
      hit = cmd_r.valid && cmd_r.score_rd_ok;
    end else begin
      inc = cmd_r.valid && (cmd_r.rows > csmh_pkg::ROWS_W'(ROW_IDX));
      hit = cmd_r.valid && cmd_r.mass_rd_ok && (cmd_r.read_row == 8'(ROW_IDX));
    end
  end

  // Write port: clearing pass, or a saturating increment.
  always_comb begin
    if (clr.active) begin
      we = 32'(clr.addr) < DEPTH;
      wa = clr.addr[AW-1:0];
      wd = '0;
    end else begin
      we = en && inc;
      wa = cur_addr;
      wd = (cur == '1) ? cur : cur + 1'b1;
    end
  end

  // Counter memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (en) begin
      rd_r    <= mem[rd_addr];
      byp_d_r <= wd;
    end
  end

  // Held transaction and forwarding flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r.valid <= 1'b0;
      byp_r       <= 1'b0;
    end else if (en) begin
      cmd_r <= cmd_in;
      byp_r <= we && (wa == rd_addr);
    end
  end

  // Hand the transaction on, with the counter filled in on a read hit.
  always_comb begin
    cmd_out = cmd_r;
    if (hit) begin
      cmd_out.count = cur;
    end
  end

endmodule

@@ design/csmh_checker.sv @@
// Port-level checks of the cut scan mass histogram top level.
// Depends on nothing but the top level's ports; attached by bind below.
module csmh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A result held back by the sink keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during clearing pass");

  // A blocked result freezes the chain, so no new transaction is taken.
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // A result that is not accepted fills no cut rows.
  a_rows_need_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'd0)
    else $error("rows filled without acceptance");

  // A nonzero counter value only comes with a read, never with an accepted candidate.
  a_count_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[39:8] != 32'd0) |-> !out_tuser[0] && out_tdata[7:0] == 8'd0)
    else $error("counter value on a candidate result");

endmodule

bind cut_scan_mass_histogram_top csmh_checker u_csmh_checker (.*);
